// File: src/kbh_pkg.sv
// ----------------------------------------------------------------------------
// kbh_pkg
// Shared types, constants and key code tables for the HID report block.
// ----------------------------------------------------------------------------
package kbh_pkg;

   localparam int KEY_CODES = 768;
   localparam int CODE_W    = 10;
   localparam int ADDR_W    = $clog2(KEY_CODES);
   localparam int SLOTS     = 6;
   localparam int NUM_PLAIN = 66;
   localparam int NUM_USAGE = 74;
   localparam int IDX_W     = 7;

   localparam logic [7:0] USAGE_FIRST = 8'h04;
   localparam logic [7:0] USAGE_MOD   = 8'he0;

   localparam logic OP_EVENT  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic [1:0] VAL_RELEASE = 2'd0;
   localparam logic [1:0] VAL_INVALID = 2'd3;

   typedef struct packed {
      logic              is_report;
      logic [CODE_W-1:0] code;
      logic              down;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } back_ctl_type;

   typedef struct packed {
      logic             mapped;
      logic [IDX_W-1:0] idx;
   } map_type;

   // key code -> compact usage index (usages 0x04..0x45, then 0xe0..0xe7)
   function automatic map_type code_map(input logic [CODE_W-1:0] code);
      map_type r;
      r = '{1'b0, '0};
      case (code)
         10'h002: r = '{1'b1, 7'd26};
         10'h003: r = '{1'b1, 7'd27};
         10'h004: r = '{1'b1, 7'd28};
         10'h005: r = '{1'b1, 7'd29};
         10'h006: r = '{1'b1, 7'd30};
         10'h007: r = '{1'b1, 7'd31};
         10'h008: r = '{1'b1, 7'd32};
         10'h009: r = '{1'b1, 7'd33};
         10'h00a: r = '{1'b1, 7'd34};
         10'h00b: r = '{1'b1, 7'd35};
         10'h01d: r = '{1'b1, 7'd66};
         10'h02a: r = '{1'b1, 7'd67};
         10'h038: r = '{1'b1, 7'd68};
         10'h07d: r = '{1'b1, 7'd69};
         10'h061: r = '{1'b1, 7'd70};
         10'h036: r = '{1'b1, 7'd71};
         10'h064: r = '{1'b1, 7'd72};
         10'h07e: r = '{1'b1, 7'd73};
         10'h01e: r = '{1'b1, 7'd0};
         10'h030: r = '{1'b1, 7'd1};
         10'h02e: r = '{1'b1, 7'd2};
         10'h020: r = '{1'b1, 7'd3};
         10'h012: r = '{1'b1, 7'd4};
         10'h021: r = '{1'b1, 7'd5};
         10'h022: r = '{1'b1, 7'd6};
         10'h023: r = '{1'b1, 7'd7};
         10'h017: r = '{1'b1, 7'd8};
         10'h024: r = '{1'b1, 7'd9};
         10'h025: r = '{1'b1, 7'd10};
         10'h026: r = '{1'b1, 7'd11};
         10'h032: r = '{1'b1, 7'd12};
         10'h031: r = '{1'b1, 7'd13};
         10'h018: r = '{1'b1, 7'd14};
         10'h019: r = '{1'b1, 7'd15};
         10'h010: r = '{1'b1, 7'd16};
         10'h013: r = '{1'b1, 7'd17};
         10'h01f: r = '{1'b1, 7'd18};
         10'h014: r = '{1'b1, 7'd19};
         10'h016: r = '{1'b1, 7'd20};
         10'h02f: r = '{1'b1, 7'd21};
         10'h011: r = '{1'b1, 7'd22};
         10'h02d: r = '{1'b1, 7'd23};
         10'h015: r = '{1'b1, 7'd24};
         10'h02c: r = '{1'b1, 7'd25};
         10'h01c: r = '{1'b1, 7'd36};
         10'h001: r = '{1'b1, 7'd37};
         10'h00e: r = '{1'b1, 7'd38};
         10'h00f: r = '{1'b1, 7'd39};
         10'h039: r = '{1'b1, 7'd40};
         10'h00c: r = '{1'b1, 7'd41};
         10'h00d: r = '{1'b1, 7'd42};
         10'h01a: r = '{1'b1, 7'd43};
         10'h01b: r = '{1'b1, 7'd44};
         10'h02b: r = '{1'b1, 7'd45};
         10'h027: r = '{1'b1, 7'd47};
         10'h028: r = '{1'b1, 7'd48};
         10'h029: r = '{1'b1, 7'd49};
         10'h033: r = '{1'b1, 7'd50};
         10'h034: r = '{1'b1, 7'd51};
         10'h035: r = '{1'b1, 7'd52};
         10'h03a: r = '{1'b1, 7'd53};
         10'h03b: r = '{1'b1, 7'd54};
         10'h03c: r = '{1'b1, 7'd55};
         10'h03d: r = '{1'b1, 7'd56};
         10'h03e: r = '{1'b1, 7'd57};
         10'h03f: r = '{1'b1, 7'd58};
         10'h040: r = '{1'b1, 7'd59};
         10'h041: r = '{1'b1, 7'd60};
         10'h042: r = '{1'b1, 7'd61};
         10'h043: r = '{1'b1, 7'd62};
         10'h044: r = '{1'b1, 7'd63};
         10'h057: r = '{1'b1, 7'd64};
         10'h058: r = '{1'b1, 7'd65};
         default: r = '{1'b0, '0};
      endcase
      return r;
   endfunction

   function automatic logic [7:0] idx_usage(input logic [IDX_W-1:0] idx);
      logic [7:0] u;
      if (idx < IDX_W'(NUM_PLAIN)) begin
         u = {1'b0, idx} + USAGE_FIRST;
      end else begin
         u = {1'b0, idx} - 8'(NUM_PLAIN) + USAGE_MOD;
      end
      return u;
   endfunction

endpackage

// File: src/kbh_ram.sv
// ----------------------------------------------------------------------------
// kbh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module kbh_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/kbh_front.sv
// ----------------------------------------------------------------------------
// kbh_front
// Accepts transactions, drops ignored events and queues the rest.
// ----------------------------------------------------------------------------
module kbh_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,
   input  logic                      req_tuser,
   input  kbh_pkg::back_ctl_type     ctl,
   output kbh_pkg::head_type         head
);
   import kbh_pkg::*;

   entry_type         q_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [CODE_W-1:0] code;
   logic [1:0]        value;
   logic              push, keep;
   entry_type         ent;

   assign code  = req_tdata[9:0];
   assign value = req_tdata[11:10];

   assign req_tready = ctl.init_done && (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign keep       = (req_tuser == OP_REPORT) ||
                       (({1'b0, code} < 11'(KEY_CODES)) && (value != VAL_INVALID));
   assign ent        = '{req_tuser == OP_REPORT, code, value != VAL_RELEASE};

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push && keep) begin
         wp_in  = ~wp_ff;
         cnt_in = cnt_in + 2'd1;
      end
      if (ctl.pop) begin
         rp_in  = ~rp_ff;
         cnt_in = cnt_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push && keep) begin
         q_ff[wp_ff] <= ent;
      end
   end

   assign head = '{cnt_ff != 2'd0, q_ff[rp_ff]};

endmodule

// File: src/kbh_back.sv
// ----------------------------------------------------------------------------
// kbh_back
// Key bitmap update, pending tracking and report scan.
// ----------------------------------------------------------------------------
module kbh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  kbh_pkg::head_type     head,
   output kbh_pkg::back_ctl_type ctl,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,
   output logic                  rsp_tuser
);
   import kbh_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_SCAN   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic                  down_ff, down_in;
   logic                  pend_ff, pend_in;
   logic [NUM_USAGE-1:0]  usage_ff, usage_in;
   logic [NUM_USAGE-1:0]  shift_ff, shift_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [7:0]            slot_ff [SLOTS];
   logic [7:0]            slot_in [SLOTS];
   logic [3:0]            lmod_ff, lmod_in, rmod_ff, rmod_in;
   logic                  valid_ff, valid_in;
   logic                  rdy_ff, rdy_in;
   logic                  ram_we, ram_wdata, ram_rdata;
   logic [ADDR_W-1:0]     ram_addr;
   logic                  pop;
   map_type               mp;

   kbh_ram #(.WIDTH(1), .DEPTH(KEY_CODES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign mp = code_map(code_ff);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      code_in   = code_ff;
      down_in   = down_ff;
      pend_in   = pend_ff;
      usage_in  = usage_ff;
      shift_in  = shift_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      slot_in   = slot_ff;
      lmod_in   = lmod_ff;
      rmod_in   = rmod_ff;
      rdy_in    = rdy_ff;
      valid_in  = valid_ff && !rsp_tready;
      ram_we    = 1'b0;
      ram_wdata = 1'b0;
      ram_addr  = ADDR_W'(head.entry.code);
      pop       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(KEY_CODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid && !head.entry.is_report) begin
               pop      = 1'b1;
               code_in  = head.entry.code;
               down_in  = head.entry.down;
               state_in = ST_UPDATE;
            end else if (head.valid && !valid_ff) begin
               pop = 1'b1;
               for (int i = 0; i < SLOTS; i++) begin
                  slot_in[i] = '0;
               end
               cnt_in = '0;
               idx_in = '0;
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  shift_in = usage_ff;
                  lmod_in  = usage_ff[NUM_PLAIN+3:NUM_PLAIN];
                  rmod_in  = usage_ff[NUM_PLAIN+7:NUM_PLAIN+4];
                  rdy_in   = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  lmod_in  = '0;
                  rmod_in  = '0;
                  rdy_in   = 1'b0;
                  valid_in = 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            ram_we    = 1'b1;
            ram_addr  = ADDR_W'(code_ff);
            ram_wdata = down_ff;
            if (ram_rdata != down_ff) begin
               pend_in = 1'b1;
            end
            if (mp.mapped) begin
               usage_in[mp.idx] = down_ff;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (shift_ff[0] && (cnt_ff != 3'(SLOTS))) begin
               slot_in[cnt_ff] = idx_usage(idx_ff);
               cnt_in          = cnt_ff + 3'd1;
            end
            shift_in = shift_ff >> 1;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(NUM_USAGE - 1)) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         usage_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         usage_ff <= usage_in;
         valid_ff <= valid_in;
      end
      code_ff  <= code_in;
      down_ff  <= down_in;
      shift_ff <= shift_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      slot_ff  <= slot_in;
      lmod_ff  <= lmod_in;
      rmod_ff  <= rmod_in;
      rdy_ff   <= rdy_in;
   end

   assign ctl        = '{pop, state_ff != ST_CLEAR};
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = rdy_ff;
   assign rsp_tdata  = {slot_ff[5], slot_ff[4], slot_ff[3], slot_ff[2], slot_ff[1],
                        slot_ff[0], rmod_ff, lmod_ff};

endmodule

// File: src/keyboard_event_to_hid_report.sv
// ----------------------------------------------------------------------------
// keyboard_event_to_hid_report
// Key events in, HID boot keyboard reports out.
// ----------------------------------------------------------------------------
// channel   dir   tdata                         tuser
// req_      in    key_code, key_value           opcode
// rsp_      out   modifiers, key slots 0..5     report_ready
//
// Key event: the back end reads the bitmap RAM in IDLE, then writes it in UPDATE.
// Report request: an empty report if nothing is pending, else a scan of one usage per
// cycle over 74 usages. After reset a RAM clear over all 768 key codes runs with
// req_tready low. A two-entry queue decouples intake from the back end;
// a report waits while the previous transaction is not yet taken.
// ----------------------------------------------------------------------------
module keyboard_event_to_hid_report (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_code[9:0], key_value[11:10], zero
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // left_modifiers, right_modifiers, key_slot_0..5
   output logic        rsp_tuser    // report_ready
);
   import kbh_pkg::*;

   head_type     head;
   back_ctl_type ctl;

   kbh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctl        (ctl),
      .head       (head)
   );

   kbh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .ctl        (ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: src/kbh_checker.sv
// ----------------------------------------------------------------------------
// kbh_checker
// Port-level checks for the HID report block.
// ----------------------------------------------------------------------------
module kbh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("outputs active after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled transaction changed");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 56'd0)
      else $error("empty report carries data");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[23:16] == 8'd0 || rsp_tdata[15:8]  < rsp_tdata[23:16]) &&
         (rsp_tdata[31:24] == 8'd0 || rsp_tdata[23:16] < rsp_tdata[31:24]) &&
         (rsp_tdata[39:32] == 8'd0 || rsp_tdata[31:24] < rsp_tdata[39:32]) &&
         (rsp_tdata[47:40] == 8'd0 || rsp_tdata[39:32] < rsp_tdata[47:40]) &&
         (rsp_tdata[55:48] == 8'd0 || rsp_tdata[47:40] < rsp_tdata[55:48]))
      else $error("key slots not ascending");

endmodule

bind keyboard_event_to_hid_report kbh_checker u_kbh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives key events and report requests into the HID report block and checks
// every response against a scoreboard that tracks the key bitmap itself.
// ----------------------------------------------------------------------------
import kbh_pkg::*;

typedef struct packed {
   logic            ready;
   logic [3:0]      left_mod;
   logic [3:0]      right_mod;
   logic [5:0][7:0] slot;
} hid_report_type;

class report_scoreboard;
   bit             key_down [KEY_CODES];
   bit             pending;
   hid_report_type expected_reports [$];
   int             errors;

   function new();
      pending = 0;
      errors  = 0;
   endfunction

   function automatic logic [7:0] code_usage(int code);
      case (code)
         'h02: return 8'h1e; 'h03: return 8'h1f; 'h04: return 8'h20;
         'h05: return 8'h21; 'h06: return 8'h22; 'h07: return 8'h23;
         'h08: return 8'h24; 'h09: return 8'h25; 'h0a: return 8'h26;
         'h0b: return 8'h27;
         'h1d: return 8'he0; 'h2a: return 8'he1; 'h38: return 8'he2;
         'h7d: return 8'he3; 'h61: return 8'he4; 'h36: return 8'he5;
         'h64: return 8'he6; 'h7e: return 8'he7;
         'h1e: return 8'h04; 'h30: return 8'h05; 'h2e: return 8'h06;
         'h20: return 8'h07; 'h12: return 8'h08; 'h21: return 8'h09;
         'h22: return 8'h0a; 'h23: return 8'h0b; 'h17: return 8'h0c;
         'h24: return 8'h0d; 'h25: return 8'h0e; 'h26: return 8'h0f;
         'h32: return 8'h10; 'h31: return 8'h11; 'h18: return 8'h12;
         'h19: return 8'h13; 'h10: return 8'h14; 'h13: return 8'h15;
         'h1f: return 8'h16; 'h14: return 8'h17; 'h16: return 8'h18;
         'h2f: return 8'h19; 'h11: return 8'h1a; 'h2d: return 8'h1b;
         'h15: return 8'h1c; 'h2c: return 8'h1d;
         'h1c: return 8'h28; 'h01: return 8'h29; 'h0e: return 8'h2a;
         'h0f: return 8'h2b; 'h39: return 8'h2c; 'h0c: return 8'h2d;
         'h0d: return 8'h2e; 'h1a: return 8'h2f; 'h1b: return 8'h30;
         'h2b: return 8'h31; 'h27: return 8'h33; 'h28: return 8'h34;
         'h29: return 8'h35; 'h33: return 8'h36; 'h34: return 8'h37;
         'h35: return 8'h38; 'h3a: return 8'h39;
         'h3b: return 8'h3a; 'h3c: return 8'h3b; 'h3d: return 8'h3c;
         'h3e: return 8'h3d; 'h3f: return 8'h3e; 'h40: return 8'h3f;
         'h41: return 8'h40; 'h42: return 8'h41; 'h43: return 8'h42;
         'h44: return 8'h43; 'h57: return 8'h44; 'h58: return 8'h45;
         default: return 8'h00;
      endcase
   endfunction

   function void note_request(logic opcode, logic [9:0] code, logic [1:0] value);
      hid_report_type r;
      bit             usage_on [256];
      int             n;
      int             mods [8] = '{'h1d, 'h2a, 'h38, 'h7d, 'h61, 'h36, 'h64, 'h7e};
      logic [7:0]     u;
      if (opcode == OP_EVENT) begin
         if (code < KEY_CODES && value != VAL_INVALID) begin
            if (key_down[code] != (value != VAL_RELEASE)) pending = 1;
            key_down[code] = (value != VAL_RELEASE);
         end
         return;
      end
      r = '0;
      if (pending) begin
         pending = 0;
         r.ready = 1;
         for (int i = 0; i < 8; i++) begin
            if (key_down[mods[i]]) begin
               if (i < 4) r.left_mod[i] = 1;
               else r.right_mod[i-4] = 1;
            end
         end
         foreach (usage_on[i]) usage_on[i] = 0;
         for (int c = 0; c < 256; c++) begin
            u = code_usage(c);
            if (key_down[c] && u != 0) usage_on[u] = 1;
         end
         n = 0;
         for (int k = 'h04; k < 'he8 && n < 6; k++) begin
            if (usage_on[k]) begin
               r.slot[n] = k[7:0];
               n++;
            end
         end
      end
      expected_reports.push_back(r);
   endfunction

   function void check_report(logic [55:0] data, logic user);
      hid_report_type e;
      if (expected_reports.size() == 0) begin
         $display("%0t: unexpected response tdata=%h tuser=%b", $time, data, user);
         errors++;
         return;
      end
      e = expected_reports.pop_front();
      if (user !== e.ready) begin
         $display("%0t: report_ready exp %b got %b", $time, e.ready, user);
         errors++;
      end
      if (data[3:0] !== e.left_mod) begin
         $display("%0t: left_modifiers exp %h got %h", $time, e.left_mod, data[3:0]);
         errors++;
      end
      if (data[7:4] !== e.right_mod) begin
         $display("%0t: right_modifiers exp %h got %h", $time, e.right_mod, data[7:4]);
         errors++;
      end
      for (int i = 0; i < 6; i++) begin
         if (data[8+8*i +: 8] !== e.slot[i]) begin
            $display("%0t: key_slot_%0d exp %h got %h", $time, i, e.slot[i],
                     data[8+8*i +: 8]);
            errors++;
         end
      end
   endfunction
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   report_scoreboard sb = new();
   int  hold_cycles = 0;
   bit  no_gaps = 0;

   int common_codes [12] = '{'h1d, 'h2a, 'h38, 'h7d, 'h61, 'h36, 'h64, 'h7e,
                             'h1e, 'h02, 'h58, 'h3a};

   keyboard_event_to_hid_report u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send(logic opcode, logic [9:0] code, logic [1:0] value);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= opcode;
      req_tdata  <= {4'b0, value, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(opcode, code, value);
      @(negedge clock);
   endtask

   task automatic press(int code, logic [1:0] value);
      send(OP_EVENT, code[9:0], value);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (sb.expected_reports.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic int pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return common_codes[$urandom_range(0, 11)];
      if (r < 80) return $urandom_range(0, 'h7f);
      if (r < 92) return $urandom_range(0, 767);
      return $urandom_range(0, 1023);
   endfunction

   // receiver with random stalls and one long hold-off
   initial begin
      int wait_n;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         wait_n = no_gaps ? 0 : $urandom_range(0, 12);
         if (wait_n > 0) begin
            rsp_tready <= 0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_report(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      int r;
      repeat (12) @(negedge clock);
      reset <= 0;

      // directed
      send(OP_REPORT, 10'd0, 2'd0);
      press('h1e, 2'd1);
      send(OP_REPORT, 10'd0, 2'd0);
      send(OP_REPORT, 10'd0, 2'd0);
      press('h1e, 2'd2);
      press(0, 2'd1);
      press(767, 2'd1);
      press(768, 2'd1);
      press(1023, 2'd2);
      press('h30, 2'd3);
      send(OP_REPORT, 10'h3ff, 2'd3);
      foreach (common_codes[i]) press(common_codes[i], 2'd1);
      press('h58, 2'd1);
      send(OP_REPORT, 10'd0, 2'd0);
      foreach (common_codes[i]) press(common_codes[i], 2'd0);
      press(0, 2'd0);
      press(767, 2'd0);
      send(OP_REPORT, 10'd0, 2'd0);

      // long receiver hold-off while sending back to back
      hold_cycles = 400;
      no_gaps = 1;
      for (int i = 0; i < 20; i++) begin
         press(pick_code(), 2'd1);
         send(OP_REPORT, 10'd0, 2'd0);
      end
      no_gaps = 0;
      wait_drained();

      for (int i = 0; i < 1050; i++) begin
         r = $urandom_range(0, 99);
         if (i == 500) wait_drained();
         if (i > 700 && i < 800) no_gaps = 1;
         else no_gaps = 0;
         if (r < 25) send(OP_REPORT, 10'($urandom_range(0, 1023)),
                          2'($urandom_range(0, 3)));
         else if (r < 30) send(OP_EVENT, 10'($urandom_range(0, 1023)),
                               2'($urandom_range(0, 3)));
         else press(pick_code(), 2'($urandom_range(0, 2)));
      end
      send(OP_REPORT, 10'd0, 2'd0);

      wait_drained();
      repeat (200) @(negedge clock);
      if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// File: sim.f
src/kbh_pkg.sv
src/kbh_ram.sv
src/kbh_front.sv
src/kbh_back.sv
src/keyboard_event_to_hid_report.sv
src/kbh_checker.sv
tb/sv/tb_top.sv
